FILE: hw/rtl/rdr_pkg.sv
// Shared definitions for the rational divide-and-reduce block.
// Holds widths, the sequencer state type and the subtractor result struct.
// No dependencies.
package rdr_pkg;

  localparam int unsigned OP_W  = 32;               // input field width
  localparam int unsigned MAG_W = 63;               // product magnitude, up to 2^62
  localparam int unsigned DEN_W = MAG_W - 1;        // result denominator width
  localparam int unsigned ALU_W = MAG_W + 1;        // shared subtractor operand width
  localparam int unsigned CNT_W = $clog2(MAG_W);    // divide bit counter

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_D,
    S_CHECK,
    S_TWOS,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
    logic             zero;
  } alu_res_t;

endpackage

FILE: hw/rtl/rdr_alu.sv
// Shared subtract/compare unit of the rational divide-and-reduce block.
// Serves both the binary gcd steps and the restoring divide steps.
// Depends on rdr_pkg.
module rdr_alu (
  input  logic [rdr_pkg::ALU_W-1:0] x_i,
  input  logic [rdr_pkg::ALU_W-1:0] y_i,
  output rdr_pkg::alu_res_t         res_o
);

  logic [rdr_pkg::ALU_W:0] full;

  assign full          = {1'b0, x_i} - {1'b0, y_i};
  assign res_o.diff    = full[rdr_pkg::ALU_W-1:0];
  assign res_o.borrow  = full[rdr_pkg::ALU_W];
  assign res_o.zero    = (full == '0);

endmodule

FILE: hw/rtl/rational_divide_reduce.sv
// Divides a_num/a_den by b_num/b_den and reduces the quotient to lowest terms.
// Steps: a numerator and a denominator multiply, removal of common twos, a binary
//   gcd and restoring divides of numerator and denominator; the gcd and divide
//   steps share one 64-bit subtractor.
// Throughput: one item at a time; busy stays high until the result beat is issued.
// Reset: asynchronous, active low; clears the sequencer and the done strobe.
// The result beat lasts one cycle and cannot be stalled by the receiver.
module rational_divide_reduce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rdr_pkg::OP_W-1:0]    a_num_i,
  input  logic signed [rdr_pkg::OP_W-1:0]    a_den_i,
  input  logic signed [rdr_pkg::OP_W-1:0]    b_num_i,
  input  logic signed [rdr_pkg::OP_W-1:0]    b_den_i,
  output logic                               done_o,
  output logic signed [rdr_pkg::MAG_W-1:0]   quot_num_o,
  output logic        [rdr_pkg::DEN_W-1:0]   quot_den_o,
  output logic                               whole_flag_o,
  output logic                               div_zero_o
);

  localparam int unsigned OW = rdr_pkg::OP_W;
  localparam int unsigned MW = rdr_pkg::MAG_W;
  localparam int unsigned DW = rdr_pkg::DEN_W;
  localparam int unsigned AW = rdr_pkg::ALU_W;
  localparam int unsigned CW = rdr_pkg::CNT_W;

  rdr_pkg::state_e state_q, state_d;

  logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
  logic [OW-1:0] an_d, ad_d, bn_d, bd_d;
  logic          neg_q, neg_d;
  logic [MW-1:0] nm_q, nm_d, dm_q, dm_d;
  logic [MW-1:0] a_q, a_d, b_q, b_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          done_d;
  logic [MW-1:0] qnum_q, qnum_d;
  logic [DW-1:0] qden_q, qden_d;
  logic          whole_q, whole_d;
  logic          dz_q, dz_d;

  logic [OW-1:0]   mul_a, mul_b;
  logic [2*OW-1:0] prod;
  logic [AW-1:0]   alu_x, alu_y;
  logic [AW-1:0]   shifted;
  logic            qbit;
  logic [MW-1:0]   neg_nm;
  rdr_pkg::alu_res_t alu;

  function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
    mag = v[OW-1] ? (~v + OW'(1)) : v;
  endfunction

  // one multiplier, numerator product first, denominator product next
  assign mul_a = (state_q == rdr_pkg::S_MUL_N) ? an_q : ad_q;
  assign mul_b = (state_q == rdr_pkg::S_MUL_N) ? bd_q : bn_q;
  assign prod  = mul_a * mul_b;

  assign qbit    = (state_q == rdr_pkg::S_DIV_N) ? nm_q[MW-1] : dm_q[MW-1];
  assign shifted = {rem_q, qbit};
  assign neg_nm  = ~nm_q + MW'(1);

  always_comb begin
    if (state_q == rdr_pkg::S_GCD) begin
      alu_x = {1'b0, a_q};
    end else begin
      alu_x = shifted;
    end
    alu_y = {1'b0, (state_q == rdr_pkg::S_GCD) ? b_q : a_q};
  end

  rdr_alu u_alu (
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu)
  );

  assign busy = (state_q != rdr_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    an_d    = an_q;
    ad_d    = ad_q;
    bn_d    = bn_q;
    bd_d    = bd_q;
    neg_d   = neg_q;
    nm_d    = nm_q;
    dm_d    = dm_q;
    a_d     = a_q;
    b_d     = b_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    qnum_d  = qnum_q;
    qden_d  = qden_q;
    whole_d = whole_q;
    dz_d    = dz_q;

    unique case (state_q)
      rdr_pkg::S_IDLE: begin
        if (start) begin
          an_d    = mag(a_num_i);
          ad_d    = mag(a_den_i);
          bn_d    = mag(b_num_i);
          bd_d    = mag(b_den_i);
          // sign of the quotient when no part is zero
          neg_d   = a_num_i[OW-1] ^ a_den_i[OW-1] ^ b_num_i[OW-1] ^ b_den_i[OW-1];
          state_d = rdr_pkg::S_MUL_N;
        end
      end
      rdr_pkg::S_MUL_N: begin
        nm_d    = prod[MW-1:0];
        a_d     = prod[MW-1:0];
        state_d = rdr_pkg::S_MUL_D;
      end
      rdr_pkg::S_MUL_D: begin
        dm_d    = prod[MW-1:0];
        b_d     = prod[MW-1:0];
        state_d = rdr_pkg::S_CHECK;
      end
      rdr_pkg::S_CHECK: begin
        if (dm_q == '0) begin
          qnum_d  = '0;
          qden_d  = '0;
          whole_d = 1'b0;
          dz_d    = 1'b1;
          done_d  = 1'b1;
          state_d = rdr_pkg::S_IDLE;
        end else if (nm_q == '0) begin
          qnum_d  = '0;
          qden_d  = DW'(1);
          whole_d = 1'b1;
          dz_d    = 1'b0;
          done_d  = 1'b1;
          state_d = rdr_pkg::S_IDLE;
        end else begin
          state_d = rdr_pkg::S_TWOS;
        end
      end
      rdr_pkg::S_TWOS: begin
        // drop common factors of two from all four values
        if (!a_q[0] && !b_q[0]) begin
          a_d  = a_q >> 1;
          b_d  = b_q >> 1;
          nm_d = nm_q >> 1;
          dm_d = dm_q >> 1;
        end else begin
          state_d = rdr_pkg::S_GCD;
        end
      end
      rdr_pkg::S_GCD: begin
        if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (alu.zero) begin
          // a holds the odd part of the gcd
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rdr_pkg::S_DIV_N;
        end else if (alu.borrow) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          // difference of two odd values is even: halve it at once
          a_d = alu.diff[MW:1];
        end
      end
      rdr_pkg::S_DIV_N,
      rdr_pkg::S_DIV_D: begin
        if (!alu.borrow) begin
          rem_d = alu.diff[MW-1:0];
        end else begin
          rem_d = shifted[MW-1:0];
        end
        if (state_q == rdr_pkg::S_DIV_N) begin
          nm_d = {nm_q[MW-2:0], ~alu.borrow};
        end else begin
          dm_d = {dm_q[MW-2:0], ~alu.borrow};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == rdr_pkg::DIV_LAST) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = (state_q == rdr_pkg::S_DIV_N) ? rdr_pkg::S_DIV_D : rdr_pkg::S_FIN;
        end
      end
      rdr_pkg::S_FIN: begin
        // magnitudes reach 2^62 at most; clamp the positive end
        if (neg_q) begin
          qnum_d = neg_nm;
        end else if (nm_q[MW-1]) begin
          qnum_d = {1'b0, {(MW-1){1'b1}}};
        end else begin
          qnum_d = nm_q;
        end
        qden_d  = dm_q[MW-1] ? {DW{1'b1}} : dm_q[DW-1:0];
        whole_d = (dm_q == MW'(1));
        dz_d    = 1'b0;
        done_d  = 1'b1;
        state_d = rdr_pkg::S_IDLE;
      end
      default: begin
        state_d = rdr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdr_pkg::S_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q    <= an_d;
    ad_q    <= ad_d;
    bn_q    <= bn_d;
    bd_q    <= bd_d;
    neg_q   <= neg_d;
    nm_q    <= nm_d;
    dm_q    <= dm_d;
    a_q     <= a_d;
    b_q     <= b_d;
    rem_q   <= rem_d;
    qnum_q  <= qnum_d;
    qden_q  <= qden_d;
    whole_q <= whole_d;
    dz_q    <= dz_d;
  end

  assign quot_num_o   = qnum_q;
  assign quot_den_o   = qden_q;
  assign whole_flag_o = whole_q;
  assign div_zero_o   = dz_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_divzero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_zero_o) |-> (quot_num_o == '0 && quot_den_o == '0 && !whole_flag_o))
    else $error("zero denominator result not cleared");

  a_den_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !div_zero_o) |-> (quot_den_o != '0))
    else $error("valid result with zero denominator");

  a_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && whole_flag_o) |-> (quot_den_o == DW'(1)))
    else $error("whole flag without unit denominator");

  a_gcd_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdr_pkg::S_DIV_N) |-> a_q[0])
    else $error("divisor of the reduction is not odd");

endmodule

FILE: bench/rational_divide_reduce_tb.sv
// Self-checking bench for rational_divide_reduce: directed corner operands, then random ones.
// Predicts each quotient in-line and checks every done_o beat against it.
// Depends on rdr_pkg and the rational_divide_reduce RTL.
module rational_divide_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_ITEMS   = 2000;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          TAIL_CYCLES = 500;
  localparam longint      NUM_MAX     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint      NUM_MIN     = -NUM_MAX - 1;
  localparam longint      DEN_MAX     = NUM_MAX;
  localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [31:0] MOST_POS    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [rdr_pkg::OP_W-1:0] an;
    logic signed [rdr_pkg::OP_W-1:0] ad;
    logic signed [rdr_pkg::OP_W-1:0] bn;
    logic signed [rdr_pkg::OP_W-1:0] bd;
  } operands_t;

  typedef struct packed {
    logic signed [rdr_pkg::MAG_W-1:0] num;
    logic        [rdr_pkg::DEN_W-1:0] den;
    logic                             whole;
    logic                             div_zero;
  } quotient_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic signed [rdr_pkg::OP_W-1:0]  a_num = '0;
  logic signed [rdr_pkg::OP_W-1:0]  a_den = '0;
  logic signed [rdr_pkg::OP_W-1:0]  b_num = '0;
  logic signed [rdr_pkg::OP_W-1:0]  b_den = '0;
  logic                             done;
  logic signed [rdr_pkg::MAG_W-1:0] quot_num;
  logic        [rdr_pkg::DEN_W-1:0] quot_den;
  logic                             whole_flag;
  logic                             div_zero;

  operands_t operand_q[$];
  quotient_t quotients_due[$];
  int        total_items = 0;
  int        beats_taken = 0;
  int        cycles = 0;
  bit        failed = 1'b0;
  bit        no_idle = 1'b0;
  logic [2:0] hold_off = '0;

  rational_divide_reduce DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .a_num_i      (a_num),
    .a_den_i      (a_den),
    .b_num_i      (b_num),
    .b_den_i      (b_den),
    .done_o       (done),
    .quot_num_o   (quot_num),
    .quot_den_o   (quot_den),
    .whole_flag_o (whole_flag),
    .div_zero_o   (div_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Normalize signs, cross-multiply, reduce by a truncated-remainder Euclid divisor.
  function automatic quotient_t divide_reduce(operands_t op);
    longint    an, ad, bn, bd, num, den, x, y, r;
    quotient_t q;
    an = op.an;
    ad = op.ad;
    bn = op.bn;
    bd = op.bd;
    q  = '0;
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    num = an * bd;
    den = ad * bn;
    if (den == 0) begin
      q.div_zero = 1'b1;
      return q;
    end
    x = num;
    y = den;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    num = num / y;
    den = den / y;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    q.whole = (den == 1);
    // Clamp magnitudes that only the most negative input can produce.
    if (num > NUM_MAX) num = NUM_MAX;
    if (num < NUM_MIN) num = NUM_MIN;
    if (den > DEN_MAX) den = DEN_MAX;
    q.num = num[rdr_pkg::MAG_W-1:0];
    q.den = den[rdr_pkg::DEN_W-1:0];
    return q;
  endfunction

  function automatic logic [rdr_pkg::OP_W-1:0] wild_field();
    logic [rdr_pkg::OP_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 4))
          0: v = MOST_POS;
          1: v = MOST_NEG + 1;
          2: v = MOST_NEG;
          3: v = 32'd1;
          default: v = '1;
        endcase
      end
      2: begin
        v = 32'd1 << $urandom_range(0, 30);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic operands_t random_operands();
    operands_t o;
    int        k;
    int        m [4];
    case ($urandom_range(0, 3))
      0: begin
        o.an = wild_field();
        o.ad = wild_field();
        o.bn = wild_field();
        o.bd = wild_field();
      end
      1, 2: begin
        // Share a factor across fields so the reduction has real work to do.
        k = int'($urandom_range(1, 4095)) << $urandom_range(0, 8);
        foreach (m[i]) m[i] = int'($urandom_range(0, 510)) - 255;
        o.an = k * m[0];
        o.ad = k * m[1];
        o.bn = k * m[2];
        o.bd = k * m[3];
      end
      default: begin
        foreach (m[i]) m[i] = int'($urandom_range(0, 128)) - 64;
        o.an = m[0];
        o.ad = m[1];
        o.bn = m[2];
        o.bd = m[3];
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : driver
    operands_t nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      hold_off <= '0;
    end else begin
      if (start && !busy) begin
        quotients_due.push_back(divide_reduce({a_num, a_den, b_num, b_den}));
        beats_taken++;
      end
      if (!start || !busy) begin
        if (hold_off != 0 || operand_q.size() == 0) begin
          start <= 1'b0;
          if (hold_off != 0) hold_off <= hold_off - 3'd1;
        end else begin
          nxt = operand_q.pop_front();
          a_num <= nxt.an;
          a_den <= nxt.ad;
          b_num <= nxt.bn;
          b_den <= nxt.bd;
          start <= 1'b1;
          // Alternate between stretches of back-to-back beats and random gaps.
          if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
          hold_off <= no_idle ? 3'd0 : 3'($urandom_range(0, 7));
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    quotient_t exp_q;
    if (rst_n && done) begin
      if (quotients_due.size() == 0) begin
        $error("unexpected result beat: quot_num %0d quot_den %0d", quot_num, quot_den);
        failed = 1'b1;
      end else begin
        exp_q = quotients_due.pop_front();
        if (quot_num !== exp_q.num) begin
          $error("quot_num: expected %0d, got %0d", exp_q.num, quot_num);
          failed = 1'b1;
        end
        if (quot_den !== exp_q.den) begin
          $error("quot_den: expected %0d, got %0d", exp_q.den, quot_den);
          failed = 1'b1;
        end
        if (whole_flag !== exp_q.whole) begin
          $error("whole_flag: expected %0b, got %0b", exp_q.whole, whole_flag);
          failed = 1'b1;
        end
        if (div_zero !== exp_q.div_zero) begin
          $error("div_zero: expected %0b, got %0b", exp_q.div_zero, div_zero);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rational_divide_reduce_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_operands(logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
    operand_q.push_back({an, ad, bn, bd});
    total_items++;
  endtask

  initial begin
    // Directed corners: zero denominators, zero numerators, sign normalization,
    // full-scale operands and saturating quotients.
    queue_operands(32'd1, 32'd1, 32'd1, 32'd1);
    queue_operands(32'd0, 32'd5, 32'd3, 32'd7);
    queue_operands(32'd6, 32'd0, 32'd3, 32'd7);
    queue_operands(32'd6, 32'd4, 32'd0, 32'd7);
    queue_operands(32'd0, 32'd0, 32'd0, 32'd0);
    queue_operands(32'd5, 32'd3, 32'd7, 32'd0);
    queue_operands(MOST_POS, MOST_POS, MOST_POS, MOST_POS);
    queue_operands(MOST_NEG + 1, MOST_NEG + 1, MOST_NEG + 1, MOST_NEG + 1);
    queue_operands(32'd3, -32'd4, 32'd5, -32'd6);
    queue_operands(-32'd6, 32'd4, 32'd3, -32'd2);
    queue_operands(MOST_POS, 32'd1, 32'd1, MOST_POS);
    queue_operands(32'd1, MOST_POS, MOST_POS, 32'd1);
    queue_operands(MOST_NEG, -32'd1, -32'd1, MOST_NEG);
    queue_operands(MOST_NEG, 32'd1, -32'd1, MOST_NEG);
    queue_operands(32'd1, MOST_NEG, MOST_NEG, 32'd1);
    queue_operands(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    queue_operands(32'd12, 32'd18, -32'd8, 32'd27);
    queue_operands(32'h4000_0000, 32'd2, 32'h2000_0000, 32'd8);
    queue_operands('1, '1, '1, '1);
    queue_operands(32'd123456789, 32'd987654321, 32'd1000000007, 32'd998244353);
    queue_operands(32'd1836311903, 32'd1134903170, 32'd1, 32'd1);
    repeat (NUM_ITEMS) begin
      operand_q.push_back(random_operands());
      total_items++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (beats_taken != total_items || quotients_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (!failed) begin
      $display("rational_divide_reduce_tb OK");
    end else begin
      $display("rational_divide_reduce_tb NOT OK");
    end
    $finish;
  end

endmodule
